// ----- rtl/ffa_pkg.sv -----
// shared codes and defaults for the first-fit free-list allocator
`default_nettype none
package ffa_pkg;
	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_ADDR_BITS   = 16;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_REL   = 2'd2;
	localparam logic [OP_W-1:0] OP_DUMP  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/ffa_table.sv -----
// extent table memory: one write port, one registered read port
`default_nettype none
module ffa_table #(
	parameter int TABLE_DEPTH = ffa_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_BITS   = ffa_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [ADDR_BITS-1:0]           wr_start,
	input  logic [ADDR_BITS:0]             wr_size,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [ADDR_BITS-1:0]           rd_start,
	output logic [ADDR_BITS:0]             rd_size
);
	import ffa_pkg::*;

	logic [ADDR_BITS-1:0] start_mem [TABLE_DEPTH];
	logic [ADDR_BITS:0]   size_mem  [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
			size_mem[wr_addr]  <= wr_size;
		end
		rd_start <= start_mem[rd_addr];
		rd_size  <= size_mem[rd_addr];
	end
endmodule
`default_nettype wire

// ----- rtl/first_fit_free_list_allocator_core.sv -----
// top level of the first-fit free-list allocator with coalescing on release
`default_nettype none
// keeps up to TABLE_DEPTH free extents (start, size) in a small memory and serves four
// commands: add an extent in start order, allocate first fit (trim from the front, drop
// when empty), release (insert, then coalesce adjacent extents over the whole table) and
// dump (one transfer per extent, last on the final one). one command is in work at a
// time; in_stall stays high until its last result is loaded into the output register.
// the sequencer walks the table entry by entry through the single registered read port,
// with one shared add/subtract unit doing every extent compare and sum. a result waiting
// at the output does not block the next command.
module first_fit_free_list_allocator_core #(
	parameter int TABLE_DEPTH = ffa_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_BITS   = ffa_pkg::DEF_ADDR_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ffa_pkg::OP_W-1:0]      operation,
	input  logic [ADDR_BITS-1:0]          start_value,
	input  logic [ADDR_BITS:0]            size_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffa_pkg::STATUS_W-1:0]  status,
	output logic [ADDR_BITS-1:0]          start_out,
	output logic [ADDR_BITS:0]            size_out,
	output logic                          last
);
	import ffa_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = ADDR_BITS;
	localparam int SW = ADDR_BITS + 1;
	localparam int W  = ADDR_BITS + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE, S_INS_RD, S_INS_EX, S_SH_RD, S_SH_EX, S_INS_PUT,
		S_MG_RD0, S_MG_LD, S_MG_RD, S_MG_EX, S_MG_SUM, S_MG_FIN,
		S_AL_RD, S_AL_EX, S_AL_TRIM, S_RM_RD, S_RM_EX,
		S_DP_RD, S_DP_EX, S_EMIT
	} state_t;

	state_t               state_q;
	logic [OP_W-1:0]      op_q;
	logic [AW-1:0]        s_q;
	logic [SW-1:0]        z_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        widx_q;
	logic [AW-1:0]        cur_start_q;
	logic [SW-1:0]        cur_size_q;
	logic [STATUS_W-1:0]  stat_q;
	logic [AW-1:0]        res_start_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [AW-1:0]        start_out_q;
	logic [SW-1:0]        size_out_q;
	logic                 last_q;

	// table port
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [AW-1:0]        wr_start;
	logic [SW-1:0]        wr_size;
	logic [AW-1:0]        rd_start;
	logic [SW-1:0]        rd_size;

	// shared add/subtract unit
	logic [W-1:0]         alu_a;
	logic [W-1:0]         alu_b;
	logic                 alu_sub;
	logic [W-1:0]         alu_sum;
	logic                 alu_neg;
	logic                 alu_zero;
	logic                 alu_eq;
	logic [SW-1:0]        sat_size;

	logic [CW-1:0]        idx_inc;
	logic [CW-1:0]        idx_dec;
	logic                 at_end;
	logic                 room;
	logic                 out_load;

	assign idx_inc = idx_q + 1'b1;
	assign idx_dec = idx_q - 1'b1;
	assign at_end  = (idx_inc == cnt_q);
	// output register is free or being emptied by this transfer
	assign room    = !out_valid_q || !out_stall;
	// a new result enters the output register this cycle
	assign out_load = room && (state_q == S_DP_EX || state_q == S_EMIT);

	ffa_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ADDR_BITS  (ADDR_BITS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_start(wr_start),
		.wr_size (wr_size),
		.rd_addr (idx_q[IW-1:0]),
		.rd_start(rd_start),
		.rd_size (rd_size)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_INS_EX: begin
				// table start against new start
				alu_a   = W'(rd_start);
				alu_b   = W'(s_q);
				alu_sub = 1'b1;
			end
			S_AL_EX: begin
				// remaining size after the request
				alu_a   = W'(rd_size);
				alu_b   = W'(z_q);
				alu_sub = 1'b1;
			end
			S_AL_TRIM: begin
				alu_a = W'(cur_start_q);
				alu_b = W'(z_q);
			end
			S_MG_EX: begin
				// end of the open extent
				alu_a = W'(cur_start_q);
				alu_b = W'(cur_size_q);
			end
			S_MG_SUM: begin
				alu_a = W'(cur_size_q);
				alu_b = W'(rd_size);
			end
			default: begin
			end
		endcase
	end

	assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + W'(alu_sub);
	assign alu_neg  = alu_sum[W-1];
	assign alu_zero = (alu_sum == '0);
	assign alu_eq   = (alu_sum == W'(rd_start));
	assign sat_size = (|alu_sum[W-1:SW]) ? '1 : alu_sum[SW-1:0];

	// table writes
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q[IW-1:0];
		wr_start = cur_start_q;
		wr_size  = cur_size_q;
		unique case (state_q)
			S_SH_EX: begin
				// open a hole: move entry one place up
				wr_en    = 1'b1;
				wr_addr  = idx_inc[IW-1:0];
				wr_start = rd_start;
				wr_size  = rd_size;
			end
			S_INS_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = widx_q[IW-1:0];
				wr_start = s_q;
				wr_size  = z_q;
			end
			S_MG_EX: begin
				// no merge: the open extent is complete
				wr_en   = !alu_eq;
				wr_addr = widx_q[IW-1:0];
			end
			S_MG_FIN: begin
				wr_en   = 1'b1;
				wr_addr = widx_q[IW-1:0];
			end
			S_AL_TRIM: begin
				// trimmed extent stays when anything is left
				wr_en    = (cur_size_q != '0);
				wr_start = alu_sum[AW-1:0];
			end
			S_RM_EX: begin
				// close the gap: move entry one place down
				wr_en    = 1'b1;
				wr_addr  = idx_dec[IW-1:0];
				wr_start = rd_start;
				wr_size  = rd_size;
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			s_q         <= '0;
			z_q         <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			widx_q      <= '0;
			cur_start_q <= '0;
			cur_size_q  <= '0;
			stat_q      <= ST_OK;
			res_start_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			start_out_q <= '0;
			size_out_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= operation;
						s_q         <= start_value;
						z_q         <= size_value;
						idx_q       <= '0;
						widx_q      <= '0;
						res_start_q <= '0;
						stat_q      <= ST_OK;
						case (operation) inside
							OP_ADD, OP_REL: begin
								if (cnt_q == DEPTH_C) begin
									// full: drop the extent, release still coalesces
									stat_q <= ST_FULL;
									if (operation == OP_ADD || cnt_q < CW'(2)) begin
										state_q <= S_EMIT;
									end else begin
										state_q <= S_MG_RD0;
									end
								end else if (cnt_q == '0) begin
									state_q <= S_INS_PUT;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							OP_ALLOC: begin
								if (cnt_q == '0) begin
									stat_q  <= ST_NOFIT;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_AL_RD;
								end
							end
							default: begin
								if (cnt_q == '0) begin
									stat_q  <= ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_DP_RD;
								end
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_EX;
				end
				S_INS_EX: begin
					// head entry goes behind only when strictly greater,
					// later entries when greater or equal
					if ((idx_q == '0) ? (!alu_neg && !alu_zero) : !alu_neg) begin
						widx_q  <= idx_q;
						idx_q   <= cnt_q - 1'b1;
						state_q <= S_SH_RD;
					end else if (at_end) begin
						widx_q  <= cnt_q;
						state_q <= S_INS_PUT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_INS_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_EX;
				end
				S_SH_EX: begin
					if (idx_q == widx_q) begin
						state_q <= S_INS_PUT;
					end else begin
						idx_q   <= idx_dec;
						state_q <= S_SH_RD;
					end
				end
				S_INS_PUT: begin
					cnt_q  <= cnt_q + 1'b1;
					idx_q  <= '0;
					widx_q <= '0;
					if (op_q == OP_ADD || cnt_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MG_RD0;
					end
				end
				S_MG_RD0: begin
					state_q <= S_MG_LD;
				end
				S_MG_LD: begin
					cur_start_q <= rd_start;
					cur_size_q  <= rd_size;
					idx_q       <= idx_inc;
					state_q     <= S_MG_RD;
				end
				S_MG_RD: begin
					state_q <= S_MG_EX;
				end
				S_MG_EX: begin
					if (alu_eq) begin
						state_q <= S_MG_SUM;
					end else begin
						widx_q      <= widx_q + 1'b1;
						cur_start_q <= rd_start;
						cur_size_q  <= rd_size;
						if (at_end) begin
							state_q <= S_MG_FIN;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_MG_RD;
						end
					end
				end
				S_MG_SUM: begin
					cur_size_q <= sat_size;
					if (at_end) begin
						state_q <= S_MG_FIN;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_MG_RD;
					end
				end
				S_MG_FIN: begin
					cnt_q   <= widx_q + 1'b1;
					state_q <= S_EMIT;
				end
				S_AL_RD: begin
					state_q <= S_AL_EX;
				end
				S_AL_EX: begin
					if (!alu_neg) begin
						cur_start_q <= rd_start;
						cur_size_q  <= alu_sum[SW-1:0];
						res_start_q <= rd_start;
						state_q     <= S_AL_TRIM;
					end else if (at_end) begin
						stat_q  <= ST_NOFIT;
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_AL_RD;
					end
				end
				S_AL_TRIM: begin
					if (cur_size_q != '0) begin
						state_q <= S_EMIT;
					end else if (at_end) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_RM_RD;
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_EX;
				end
				S_RM_EX: begin
					if (at_end) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_RM_RD;
					end
				end
				S_DP_RD: begin
					state_q <= S_DP_EX;
				end
				S_DP_EX: begin
					// one transfer per extent
					if (room) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						start_out_q <= rd_start;
						size_out_q  <= rd_size;
						last_q      <= at_end;
						if (at_end) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_DP_RD;
						end
					end
				end
				S_EMIT: begin
					if (room) begin
						out_valid_q <= 1'b1;
						status_q    <= stat_q;
						start_out_q <= res_start_q;
						size_out_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign start_out = start_out_q;
	assign size_out  = size_out_q;
	assign last      = last_q;

	// table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("extent count above table depth");

	// only a dump gives results that are not the last
	a_multi_only_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (op_q == OP_DUMP))
		else $error("non-final result outside dump");

	// coalescing write pointer trails the read pointer
	a_merge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MG_EX) |-> (widx_q < idx_q))
		else $error("merge write overtakes read");

	// an accepted command always starts the sequencer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("sequencer idle after accepted command");
endmodule
`default_nettype wire
